>>> rtl/tccw_pkg.sv
// shared types and constants for the text console character writer
// used by tccw_front, tccw_back and the top module in rtl/, no dependencies of its own

package tccw_pkg;

	// default geometry
	localparam int COLUMNS_DEF  = 80;
	localparam int ROWS_DEF     = 25;
	localparam int TAB_SIZE_DEF = 8;

	// fixed widths of the word fields
	localparam int CELL_W = 11;
	localparam int POSX_W = 7;
	localparam int POSY_W = 5;

	// commands
	localparam logic [1:0] CMD_PUT_DEF  = 2'd0;
	localparam logic [1:0] CMD_PUT_ATTR = 2'd1;
	localparam logic [1:0] CMD_PUT_AT   = 2'd2;
	localparam logic [1:0] CMD_NONE     = 2'd3;

	// character codes
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// character classes
	localparam logic [2:0] CLS_IGNORE = 3'd0;
	localparam logic [2:0] CLS_BS     = 3'd1;
	localparam logic [2:0] CLS_TAB    = 3'd2;
	localparam logic [2:0] CLS_CR     = 3'd3;
	localparam logic [2:0] CLS_NL     = 3'd4;
	localparam logic [2:0] CLS_PRINT  = 3'd5;

	// register indexes
	localparam logic [1:0] CFG_DEFAULT_ATTR = 2'd0;
	localparam logic [1:0] CFG_CLEAR_ATTR   = 2'd1;
	localparam logic [1:0] CFG_CURSOR_GLYPH = 2'd2;
	localparam logic [1:0] CFG_CURSOR_ATTR  = 2'd3;

	// register reset values
	localparam logic [7:0] RST_DEFAULT_ATTR = 8'h0F;
	localparam logic [7:0] RST_CLEAR_ATTR   = 8'h00;
	localparam logic [7:0] RST_CURSOR_GLYPH = 8'h7C;
	localparam logic [7:0] RST_CURSOR_ATTR  = 8'h8F;

	// result slots, in output order
	localparam int RES_CHAR   = 0;
	localparam int RES_SCROLL = 1;
	localparam int RES_ERASE  = 2;
	localparam int RES_DRAW   = 3;

	// result kinds
	localparam logic KIND_CELL   = 1'b0;
	localparam logic KIND_SCROLL = 1'b1;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0] default_attr;
		logic [7:0] clear_attr;
		logic [7:0] cursor_glyph;
		logic [7:0] cursor_attr;
	} cfg_t;

	// classified word handed from front to back
	typedef struct packed {
		logic              is_pos;
		logic [2:0]        cls;
		logic [7:0]        char_code;
		logic [7:0]        attr;
		logic [POSX_W-1:0] pos_x;
		logic [POSY_W-1:0] pos_y;
	} item_t;

endpackage

>>> rtl/tccw_fifo.sv
// small register queue between front and back
// generic payload vector, no package dependency

module tccw_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             not_full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign not_full  = (count_q != CntW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/tccw_front.sv
// input side: takes words, classifies the character, picks the attribute and saturates the position
// depends on tccw_pkg

module tccw_front #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,
	input  logic [1:0]          s_tuser,
	input  tccw_pkg::cfg_t      cfg,
	input  logic                queue_not_full,
	output logic                push,
	output tccw_pkg::item_t     item
);

	logic [7:0]                  ch;
	logic [7:0]                  attr_in;
	logic [tccw_pkg::POSX_W-1:0] px;
	logic [tccw_pkg::POSY_W-1:0] py;
	logic [1:0]                  cmd;

	assign cmd     = s_tuser;
	assign ch      = s_tdata[7:0];
	assign attr_in = s_tdata[15:8];
	assign px      = s_tdata[22:16];
	assign py      = s_tdata[27:23];

	assign s_tready = queue_not_full;
	// the no-op command is taken and dropped
	assign push     = s_tvalid && queue_not_full && (cmd != tccw_pkg::CMD_NONE);

	always_comb begin
		item           = '0;
		item.is_pos    = (cmd == tccw_pkg::CMD_PUT_AT);
		item.char_code = ch;
		item.attr      = (cmd == tccw_pkg::CMD_PUT_DEF) ? cfg.default_attr : attr_in;
		item.pos_x     = ({1'b0, px} < (tccw_pkg::POSX_W + 1)'(COLUMNS)) ? px
			: tccw_pkg::POSX_W'(COLUMNS - 1);
		// two extra bits so the full row count fits in the compare
		item.pos_y     = ({2'b0, py} < (tccw_pkg::POSY_W + 2)'(ROWS)) ? py
			: tccw_pkg::POSY_W'(ROWS - 1);
		if (ch == tccw_pkg::CH_BS) begin
			item.cls = tccw_pkg::CLS_BS;
		end else if (ch == tccw_pkg::CH_TAB) begin
			item.cls = tccw_pkg::CLS_TAB;
		end else if (ch == tccw_pkg::CH_CR) begin
			item.cls = tccw_pkg::CLS_CR;
		end else if (ch == tccw_pkg::CH_LF) begin
			item.cls = tccw_pkg::CLS_NL;
		end else if (!ch[7] && ch >= tccw_pkg::CH_SPACE) begin
			item.cls = tccw_pkg::CLS_PRINT;
		end else begin
			item.cls = tccw_pkg::CLS_IGNORE;
		end
	end

endmodule

>>> rtl/tccw_back.sv
// execution side: cursor state, per-word result plan and the output register
// depends on tccw_pkg

module tccw_back #(
	parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS     = tccw_pkg::ROWS_DEF,
	parameter int TAB_SIZE = tccw_pkg::TAB_SIZE_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tccw_pkg::cfg_t  cfg,
	input  logic            item_valid,
	output logic            item_pop,
	input  tccw_pkg::item_t item,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [31:0]     m_tdata,
	output logic            m_tuser,
	output logic            m_tlast
);

	localparam int ColW    = $clog2(COLUMNS);
	localparam int RowW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ExtW    = $clog2(COLUMNS + TAB_SIZE);
	localparam int RowExtW = $clog2(ROWS + 1);
	localparam int MulW    = RowW + $clog2(COLUMNS + 1) + 1;
	localparam int CellW   = tccw_pkg::CELL_W;

	function automatic logic [CellW-1:0] cell_of(input logic [RowW-1:0] r,
		input logic [ColW-1:0] c);
		logic [MulW-1:0] full;
		full = MulW'(r) * MulW'(COLUMNS) + MulW'(c);
		return CellW'(full);
	endfunction

	// next tab stop for every column
	logic [ExtW-1:0] tab_stop [COLUMNS];
	for (genvar i = 0; i < COLUMNS; i++) begin : g_tab
		localparam int Nxt = i + TAB_SIZE - (i % TAB_SIZE);
		assign tab_stop[i] = ExtW'(Nxt);
	end

	logic [RowW-1:0]  row_q;
	logic [ColW-1:0]  col_q;
	logic [CellW-1:0] old_q;

	logic             plan_valid_q;
	logic [3:0]       mask_q;
	logic [CellW-1:0] char_cell_q;
	logic [7:0]       char_glyph_q;
	logic [7:0]       char_attr_q;
	logic [CellW-1:0] erase_cell_q;
	logic [CellW-1:0] draw_cell_q;

	logic             out_valid_q;
	logic [CellW-1:0] out_cell_q;
	logic [7:0]       out_glyph_q;
	logic [7:0]       out_attr_q;
	logic             out_kind_q;
	logic             out_last_q;

	// execution of the word at the head of the queue
	logic [RowW-1:0]    cur_row;
	logic [ColW-1:0]    cur_col;
	logic [ExtW-1:0]    col_n;
	logic [RowExtW-1:0] row_n;
	logic               erase;
	logic               has_char;
	logic               scroll;
	logic [CellW-1:0]   old_e;
	logic [RowW-1:0]    row_f;
	logic [ColW-1:0]    col_f;
	logic [CellW-1:0]   draw_cell;

	always_comb begin
		cur_col  = item.is_pos ? ColW'(item.pos_x) : col_q;
		cur_row  = item.is_pos ? RowW'(item.pos_y) : row_q;
		col_n    = ExtW'(cur_col);
		row_n    = RowExtW'(cur_row);
		erase    = 1'b0;
		has_char = 1'b0;
		old_e    = old_q;
		case (item.cls)
			tccw_pkg::CLS_BS: begin
				if (cur_col != '0) begin
					erase = 1'b1;
					col_n = ExtW'(cur_col) - 1'b1;
				end
			end
			tccw_pkg::CLS_TAB: begin
				erase = 1'b1;
				col_n = tab_stop[cur_col];
			end
			tccw_pkg::CLS_CR: begin
				erase = 1'b1;
				col_n = '0;
			end
			tccw_pkg::CLS_NL: begin
				erase = 1'b1;
				col_n = '0;
				row_n = row_n + 1'b1;
			end
			tccw_pkg::CLS_PRINT: begin
				has_char = 1'b1;
				col_n    = col_n + 1'b1;
			end
			default: ;
		endcase
		// full row wraps
		if (col_n >= ExtW'(COLUMNS)) begin
			col_n = '0;
			row_n = row_n + 1'b1;
		end
		// past the bottom row: scroll, old cursor moves up or drops off the top
		scroll = (row_n >= RowExtW'(ROWS));
		if (scroll) begin
			row_n = RowExtW'(ROWS - 1);
			if (old_q >= CellW'(COLUMNS)) begin
				old_e = old_q - CellW'(COLUMNS);
				erase = 1'b1;
			end else begin
				erase = 1'b0;
			end
		end
		row_f     = RowW'(row_n);
		col_f     = ColW'(col_n);
		draw_cell = cell_of(row_f, col_f);
	end

	// result selection from the plan, in fixed order
	logic       out_load;
	logic [3:0] sel;
	logic [3:0] mask_rest;
	logic       sel_last;

	always_comb begin
		if (mask_q[tccw_pkg::RES_CHAR]) begin
			sel = 4'b0001 << tccw_pkg::RES_CHAR;
		end else if (mask_q[tccw_pkg::RES_SCROLL]) begin
			sel = 4'b0001 << tccw_pkg::RES_SCROLL;
		end else if (mask_q[tccw_pkg::RES_ERASE]) begin
			sel = 4'b0001 << tccw_pkg::RES_ERASE;
		end else begin
			sel = 4'b0001 << tccw_pkg::RES_DRAW;
		end
		mask_rest = mask_q & ~sel;
		sel_last  = (mask_rest == '0);
	end

	assign out_load = plan_valid_q && (!out_valid_q || m_tready);
	assign item_pop = item_valid && (!plan_valid_q || (out_load && sel_last));

	// cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			old_q <= '0;
		end else if (item_pop) begin
			if (!item.is_pos) begin
				row_q <= row_f;
				col_q <= col_f;
			end
			old_q <= draw_cell;
		end
	end

	// plan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan_valid_q <= 1'b0;
			mask_q       <= '0;
		end else if (item_pop) begin
			plan_valid_q                 <= 1'b1;
			mask_q[tccw_pkg::RES_CHAR]   <= has_char;
			mask_q[tccw_pkg::RES_SCROLL] <= scroll;
			mask_q[tccw_pkg::RES_ERASE]  <= erase;
			mask_q[tccw_pkg::RES_DRAW]   <= 1'b1;
		end else if (out_load) begin
			mask_q <= mask_rest;
			if (sel_last) begin
				plan_valid_q <= 1'b0;
			end
		end
	end

	// plan payload
	always_ff @(posedge clk) begin
		if (item_pop) begin
			char_cell_q  <= cell_of(cur_row, cur_col);
			char_glyph_q <= item.char_code;
			char_attr_q  <= item.attr;
			erase_cell_q <= old_e;
			draw_cell_q  <= draw_cell;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_last_q <= sel_last;
			out_kind_q <= sel[tccw_pkg::RES_SCROLL] ? tccw_pkg::KIND_SCROLL
				: tccw_pkg::KIND_CELL;
			if (sel[tccw_pkg::RES_CHAR]) begin
				out_cell_q  <= char_cell_q;
				out_glyph_q <= char_glyph_q;
				out_attr_q  <= char_attr_q;
			end else if (sel[tccw_pkg::RES_SCROLL]) begin
				out_cell_q  <= '0;
				out_glyph_q <= '0;
				out_attr_q  <= '0;
			end else if (sel[tccw_pkg::RES_ERASE]) begin
				out_cell_q  <= erase_cell_q;
				out_glyph_q <= tccw_pkg::CH_SPACE;
				out_attr_q  <= cfg.clear_attr;
			end else begin
				out_cell_q  <= draw_cell_q;
				out_glyph_q <= cfg.cursor_glyph;
				out_attr_q  <= cfg.cursor_attr;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {5'b0, out_attr_q, out_glyph_q, out_cell_q};

endmodule

>>> rtl/text_console_char_writer.sv
// text console character writer: cursor control and cell writes for a text screen
// a word taken into an idle block passes the queue, the result plan and the output register on its way to m
// results: one per cycle while m_tready allows, one to four per executed word, none for a dropped one
// reset: cursor row, column and old cursor cell to zero, registers to their defaults,
// the queue and the output register empty, no clearing pass
// depends on tccw_pkg, tccw_front, tccw_fifo, tccw_back

module text_console_char_writer #(
	parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS     = tccw_pkg::ROWS_DEF,
	parameter int TAB_SIZE = tccw_pkg::TAB_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // char_code[7:0], attribute[15:8], pos_x[22:16],
	                              // pos_y[27:23], zero[31:28]
	input  logic [1:0]  s_tuser,  // command[1:0]
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // cell_index[10:0], glyph[18:11],
	                              // cell_attribute[26:19], zero[31:27]
	output logic        m_tuser,  // kind[0]
	output logic        m_tlast   // last result of the input word
);

	// configuration registers, to be written only while idle; the block itself does not enforce it
	tccw_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.default_attr <= tccw_pkg::RST_DEFAULT_ATTR;
			cfg_q.clear_attr   <= tccw_pkg::RST_CLEAR_ATTR;
			cfg_q.cursor_glyph <= tccw_pkg::RST_CURSOR_GLYPH;
			cfg_q.cursor_attr  <= tccw_pkg::RST_CURSOR_ATTR;
		end else if (cfg_we) begin
			case (cfg_index)
				tccw_pkg::CFG_DEFAULT_ATTR: cfg_q.default_attr <= cfg_data;
				tccw_pkg::CFG_CLEAR_ATTR:   cfg_q.clear_attr   <= cfg_data;
				tccw_pkg::CFG_CURSOR_GLYPH: cfg_q.cursor_glyph <= cfg_data;
				tccw_pkg::CFG_CURSOR_ATTR:  cfg_q.cursor_attr  <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: accept and classify, drop no-op commands
	logic            queue_not_full;
	logic            push;
	tccw_pkg::item_t push_item;

	tccw_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.cfg            (cfg_q),
		.queue_not_full (queue_not_full),
		.push           (push),
		.item           (push_item)
	);

	// short queue so the front keeps taking words while the back emits
	logic            queue_not_empty;
	logic            pop;
	tccw_pkg::item_t pop_item;

	tccw_fifo #(
		.WIDTH ($bits(tccw_pkg::item_t)),
		.DEPTH (tccw_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_item),
		.not_full  (queue_not_full),
		.pop       (pop),
		.not_empty (queue_not_empty),
		.pop_data  (pop_item)
	);

	// back: cursor update, result plan, output register
	tccw_back #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_SIZE (TAB_SIZE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (queue_not_empty),
		.item_pop   (pop),
		.item       (pop_item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for text_console_char_writer: directed table, then random words
// predicts cell writes, scroll requests and cursor redraws; depends on tccw_pkg and the rtl

module tb;
	import tccw_pkg::*;

	localparam int COLUMNS     = COLUMNS_DEF;
	localparam int ROWS        = ROWS_DEF;
	localparam int TAB_SIZE    = TAB_SIZE_DEF;
	localparam int STALL_LIMIT = 1000;  // cycles with no handshake at all
	localparam int SETTLE      = 8;     // extra wait after the last expected result
	localparam int PHASE_WORDS = 86;    // counted words per random phase

	// one input word as the block sees it
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] ch;
		logic [7:0] attr;
		logic [6:0] px;
		logic [4:0] py;
	} word_t;

	// one result word
	typedef struct packed {
		logic        kind;
		logic [10:0] cell_idx;
		logic [7:0]  glyph;
		logic [7:0]  attr;
		logic        last;
	} res_t;

	// directed row: a word, and optionally its results written out by hand
	typedef struct packed {
		word_t           w;
		logic            typed;
		logic [2:0]      n_typed;
		res_t [3:0]      typed_res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	text_console_char_writer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // char_code, attribute, pos_x, pos_y, zero pad
		.s_tuser  (s_tuser),   // command
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // cell_index, glyph, cell_attribute, zero pad
		.m_tuser  (m_tuser),   // kind
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// console state as the predictor tracks it
	cfg_t        console_cfg = '{RST_DEFAULT_ATTR, RST_CLEAR_ATTR, RST_CURSOR_GLYPH,
	                             RST_CURSOR_ATTR};
	logic [4:0]  cur_row = '0;
	logic [6:0]  cur_col = '0;
	logic [10:0] old_cell = '0;
	logic        erase_due = 1'b0;

	res_t step_out[$];          // results of the word just predicted
	res_t cell_writes_due[$];   // results still to come from the block
	int   mismatches = 0;
	int   burst_left = 0;

	function automatic void emit(logic kind, logic [10:0] cell_idx, logic [7:0] g,
		logic [7:0] a);
		step_out.push_back(res_t'{kind, cell_idx, g, a, 1'b0});
	endfunction

	// one character at the cursor: moves, wraps, scrolls, then erase and redraw
	function automatic void put_char(logic [7:0] c, logic [7:0] a);
		logic [10:0] draw_idx;
		if (c == CH_BS) begin
			// backspace at column zero leaves everything where it is
			if (cur_col != 0) begin
				erase_due = 1'b1;
				cur_col = cur_col - 7'd1;
			end
		end else if (c == CH_TAB) begin
			erase_due = 1'b1;
			cur_col = 7'(int'(cur_col) + TAB_SIZE - int'(cur_col) % TAB_SIZE);
		end else if (c == CH_CR) begin
			erase_due = 1'b1;
			cur_col = '0;
		end else if (c == CH_LF) begin
			erase_due = 1'b1;
			cur_col = '0;
			cur_row = cur_row + 5'd1;
		end else if (c >= CH_SPACE && c <= 8'h7F) begin
			emit(KIND_CELL, 11'(int'(cur_row) * COLUMNS + int'(cur_col)), c, a);
			cur_col = cur_col + 7'd1;
		end
		if (cur_col >= COLUMNS) begin
			cur_col = '0;
			cur_row = cur_row + 5'd1;
		end
		// past the bottom: request a scroll, the old cursor moves up with the text
		if (cur_row >= ROWS) begin
			emit(KIND_SCROLL, '0, '0, '0);
			cur_row = 5'(ROWS - 1);
			if (old_cell >= COLUMNS) begin
				old_cell = old_cell - 11'(COLUMNS);
				erase_due = 1'b1;
			end else begin
				erase_due = 1'b0;   // it scrolled off the top
			end
		end
		if (erase_due) begin
			erase_due = 1'b0;
			emit(KIND_CELL, old_cell, CH_SPACE, console_cfg.clear_attr);
		end
		draw_idx = 11'(int'(cur_row) * COLUMNS + int'(cur_col));
		emit(KIND_CELL, draw_idx, console_cfg.cursor_glyph, console_cfg.cursor_attr);
		old_cell = draw_idx;
		step_out[step_out.size() - 1].last = 1'b1;
	endfunction

	function automatic void console_step(word_t w);
		logic [4:0] save_row;
		logic [6:0] save_col;
		step_out.delete();
		case (w.cmd)
			CMD_PUT_DEF: put_char(w.ch, console_cfg.default_attr);
			CMD_PUT_ATTR: put_char(w.ch, w.attr);
			CMD_PUT_AT: begin
				// out-of-range positions saturate, the cursor comes back afterwards
				save_row = cur_row;
				save_col = cur_col;
				cur_col = (w.px < COLUMNS) ? w.px : 7'(COLUMNS - 1);
				cur_row = (w.py < ROWS) ? w.py : 5'(ROWS - 1);
				put_char(w.ch, w.attr);
				cur_row = save_row;
				cur_col = save_col;
			end
			default: ;  // no-op command, no results
		endcase
	endfunction

	function automatic dir_row_t plain(logic [1:0] cmd, logic [7:0] ch, logic [7:0] attr,
		logic [6:0] px, logic [4:0] py);
		dir_row_t r;
		r = '0;
		r.w = '{cmd, ch, attr, px, py};
		return r;
	endfunction

	// present one word, leaving tvalid high for a following word in the burst
	task automatic send_word(dir_row_t r);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, r.w.py, r.w.px, r.w.attr, r.w.ch};
		s_tuser  <= r.w.cmd;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		console_step(r.w);
		if (r.typed) begin
			for (int k = 0; k < r.n_typed; k++)
				cell_writes_due.push_back(r.typed_res[k]);
		end else begin
			foreach (step_out[k])
				cell_writes_due.push_back(step_out[k]);
		end
	endtask

	// stop sending and let the block run dry before touching the registers
	task automatic drain_words();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (cell_writes_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// the caller drops the write enable after its last write
	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_DEFAULT_ATTR: console_cfg.default_attr = val;
			CFG_CLEAR_ATTR:   console_cfg.clear_attr   = val;
			CFG_CURSOR_GLYPH: console_cfg.cursor_glyph = val;
			default:          console_cfg.cursor_attr  = val;
		endcase
	endtask

	// all zeros, all ones, then random settings
	function automatic logic [7:0] phase_value(int phase);
		if (phase == 0)
			return 8'h00;
		if (phase == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// receiver: switches between always ready, light, periodic and heavy stalls
	int rx_tick = 0;
	int rx_mode = 0;
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_tick % 64 == 0)
			rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= (rx_tick % 5 >= 2);
			default: m_tready <= $urandom_range(0, 1);
		endcase
	end

	// result checker: every accepted result word against the oldest expectation
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tuser, m_tdata[10:0], m_tdata[18:11], m_tdata[26:19], m_tlast};
			if (cell_writes_due.size() == 0) begin
				$display("%0t: unexpected result kind=%0d cell=%0d glyph=%h attr=%h last=%0d",
					$time, got.kind, got.cell_idx, got.glyph, got.attr, got.last);
				mismatches++;
			end else begin
				want = cell_writes_due.pop_front();
				if (got !== want) begin
					$display("%0t: expected kind=%0d cell=%0d glyph=%h attr=%h last=%0d",
						$time, want.kind, want.cell_idx, want.glyph, want.attr, want.last);
					$display("%0t:   actual kind=%0d cell=%0d glyph=%h attr=%h last=%0d",
						$time, got.kind, got.cell_idx, got.glyph, got.attr, got.last);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles where nothing moves
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		dir_row_t dir_tab[$];
		dir_row_t r;
		int       counted;
		int       pick;
		word_t    w;

		// after reset: 'A' lands in cell 0, cursor redrawn in cell 1
		r = plain(CMD_PUT_DEF, 8'h41, 8'h00, 7'd0, 5'd0);
		r.typed = 1'b1;
		r.n_typed = 3'd2;
		r.typed_res[0] = '{KIND_CELL, 11'd0, 8'h41, 8'h0F, 1'b0};
		r.typed_res[1] = '{KIND_CELL, 11'd1, 8'h7C, 8'h8F, 1'b1};
		dir_tab.push_back(r);
		// no-op command with every field at its top, nothing comes out
		r = plain(CMD_NONE, 8'hFF, 8'hFF, 7'h7F, 5'h1F);
		r.typed = 1'b1;
		r.n_typed = 3'd0;
		dir_tab.push_back(r);
		dir_tab.push_back(plain(CMD_PUT_ATTR, 8'h7F, 8'hFF, 7'd0, 5'd0));   // top printable
		dir_tab.push_back(plain(CMD_PUT_ATTR, CH_SPACE, 8'h00, 7'd0, 5'd0)); // bottom printable
		dir_tab.push_back(plain(CMD_PUT_DEF, CH_BS, 8'h00, 7'd0, 5'd0));
		dir_tab.push_back(plain(CMD_PUT_DEF, CH_TAB, 8'h00, 7'd0, 5'd0));
		dir_tab.push_back(plain(CMD_PUT_DEF, CH_CR, 8'h00, 7'd0, 5'd0));
		dir_tab.push_back(plain(CMD_PUT_DEF, CH_BS, 8'h00, 7'd0, 5'd0));    // at column zero
		dir_tab.push_back(plain(CMD_PUT_DEF, CH_LF, 8'h00, 7'd0, 5'd0));
		dir_tab.push_back(plain(CMD_PUT_ATTR, 8'h00, 8'h55, 7'd0, 5'd0));   // ignored control
		dir_tab.push_back(plain(CMD_PUT_ATTR, 8'h80, 8'hAA, 7'd0, 5'd0));   // ignored high byte
		dir_tab.push_back(plain(CMD_PUT_DEF, 8'hFF, 8'h00, 7'd0, 5'd0));
		dir_tab.push_back(plain(CMD_PUT_DEF, 8'h1F, 8'h00, 7'd0, 5'd0));
		dir_tab.push_back(plain(CMD_PUT_AT, 8'h78, 8'h3C, 7'd0, 5'd0));
		// bottom-right corner: wraps and scrolls, old cursor in the top row is dropped
		dir_tab.push_back(plain(CMD_PUT_AT, 8'h79, 8'hC3, 7'd79, 5'd24));
		// saturated position, scroll now moves the old cursor erase up a row
		dir_tab.push_back(plain(CMD_PUT_AT, 8'h7A, 8'h5A, 7'h7F, 5'h1F));
		dir_tab.push_back(plain(CMD_PUT_AT, CH_TAB, 8'h00, 7'd78, 5'd24));
		dir_tab.push_back(plain(CMD_PUT_AT, CH_LF, 8'h81, 7'd0, 5'd24));
		dir_tab.push_back(plain(CMD_PUT_AT, CH_BS, 8'h7E, 7'd0, 5'd13));
		dir_tab.push_back(plain(CMD_PUT_DEF, 8'h7E, 8'h00, 7'd0, 5'd0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_word(dir_tab[i]);

		for (int phase = 0; phase < 4; phase++) begin
			drain_words();
			write_reg(CFG_DEFAULT_ATTR, phase_value(phase));
			write_reg(CFG_CLEAR_ATTR, phase_value(phase));
			write_reg(CFG_CURSOR_GLYPH, phase_value(phase));
			write_reg(CFG_CURSOR_ATTR, phase_value(phase));
			cfg_we <= 1'b0;
			counted = 0;
			while (counted < PHASE_WORDS) begin
				// printable text most often, with enough line feeds to reach the bottom and scroll
				pick = $urandom_range(0, 99);
				if (pick < 45)
					w.ch = 8'($urandom_range(8'h20, 8'h7F));
				else if (pick < 58)
					w.ch = CH_LF;
				else if (pick < 66)
					w.ch = CH_TAB;
				else if (pick < 71)
					w.ch = CH_CR;
				else if (pick < 76)
					w.ch = CH_BS;
				else if (pick < 82)
					w.ch = 8'($urandom_range(8'h00, 8'h1F));
				else
					w.ch = 8'($urandom_range(8'h80, 8'hFF));
				pick = $urandom_range(0, 99);
				w.cmd = (pick < 45) ? CMD_PUT_DEF : (pick < 80) ? CMD_PUT_ATTR :
				        (pick < 95) ? CMD_PUT_AT : CMD_NONE;
				w.attr = 8'($urandom);
				w.px = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) :
				       7'($urandom_range(0, COLUMNS - 1));
				w.py = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
				       5'($urandom_range(0, ROWS - 1));
				r = '0;
				r.w = w;
				send_word(r);
				if (w.cmd != CMD_NONE)
					counted++;
			end
		end

		drain_words();
		@(negedge clk);
		if (mismatches == 0 && cell_writes_due.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/tccw_pkg.sv
rtl/tccw_fifo.sv
rtl/tccw_front.sv
rtl/tccw_back.sv
rtl/text_console_char_writer.sv
verif/tb.sv
